// ===== rtl/pmst_pkg.sv =====
// Package for the maximum spanning tree block: sizes, mode codes and
// controller state encoding. No dependencies.
package pmst_pkg;

  localparam int unsigned NUM_V    = 64;
  localparam int unsigned VTX_W    = $clog2(NUM_V);
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned ADJ_AW   = 2 * VTX_W;
  localparam int unsigned ADJ_DW   = WEIGHT_W + 1;
  localparam int unsigned VMEM_DW  = WEIGHT_W + VTX_W;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_EDGE  = 5'b00100,
    S_QUERY = 5'b01000,
    S_SCAN  = 5'b10000
  } state_e;

endpackage

// ===== rtl/pmst_adj_ram.sv =====
// Adjacency matrix store: one entry per directed edge, {present, weight}.
// Depends on pmst_pkg.
module pmst_adj_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [pmst_pkg::ADJ_AW-1:0]  waddr_i,
  input  logic [pmst_pkg::ADJ_DW-1:0]  wdata_i,
  input  logic [pmst_pkg::ADJ_AW-1:0]  raddr_i,
  output logic [pmst_pkg::ADJ_DW-1:0]  rdata_o
);
  import pmst_pkg::*;

  logic [ADJ_DW-1:0] mem [NUM_V*NUM_V];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/pmst_vtx_ram.sv =====
// Per-vertex store: {best weight, parent index}, guarded by flags in the top.
// Depends on pmst_pkg.
module pmst_vtx_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [pmst_pkg::VTX_W-1:0]    waddr_i,
  input  logic [pmst_pkg::VMEM_DW-1:0]  wdata_i,
  input  logic [pmst_pkg::VTX_W-1:0]    raddr_i,
  output logic [pmst_pkg::VMEM_DW-1:0]  rdata_o
);
  import pmst_pkg::*;

  logic [VMEM_DW-1:0] mem [NUM_V];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/prim_max_spanning_tree_top.sv =====
// Top level of the maximum spanning tree block: command decode, clear sweep,
// Prim scan sequencer. Depends on pmst_pkg, pmst_adj_ram, pmst_vtx_ram.
//
// Usage: drive a command on mode_i and the vertex/weight fields, raise start_i;
// the transaction is taken at an edge where start_i is high and busy_o low.
// Each command yields one result, shown for one cycle with done_o high.
// The receiver cannot stall; results must be taken when done_o is high.
// cfg_we_i/cfg_wdata_i write highest_vertex; write only while idle.
// Command steps:
//   bad vertex index : result in the cycle after accept
//   add edge, query  : one read of the matrix or vertex store, then the result
//   clear graph      : all 4096 matrix entries, one matrix entry per cycle
//   run              : one adjacency row scanned per vertex joined, through
//                      the single read port of the adjacency store:
//                      one row entry is read and relaxed per cycle.
// At reset the block sweeps the adjacency store clear with
// busy_o high; no result is produced for that sweep.
module prim_max_spanning_tree_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    mode_i,
  input  logic [5:0]                    from_vertex_i,
  input  logic [5:0]                    to_vertex_i,
  input  logic signed [15:0]            edge_weight_i,
  input  logic [5:0]                    start_vertex_i,
  input  logic [5:0]                    query_vertex_i,
  input  logic                          cfg_we_i,
  input  logic [5:0]                    cfg_wdata_i,
  output logic                          done_o,
  output logic                          status_o,
  output logic [5:0]                    tree_parent_o,
  output logic                          has_parent_o,
  output logic signed [15:0]            tree_weight_o,
  output logic                          joined_tree_o
);
  import pmst_pkg::*;

  state_e state_q, state_d;
  logic [VTX_W-1:0]  top_q;
  logic [ADJ_AW-1:0] clr_addr_q, clr_addr_d;
  logic              clr_report_q, clr_report_d;

  logic [VTX_W-1:0]  from_q, to_q, qv_q, x_q, x_d;
  logic [WEIGHT_W-1:0] w_q;

  logic [NUM_V-1:0] in_tree_q, in_tree_d, reached_q, reached_d, pv_q, pv_d;

  logic [VTX_W-1:0] iss_y_q, iss_y_d, pend_y_q, pend_y_d;
  logic             iss_on_q, iss_on_d, pend_q, pend_d;
  logic             found_q, found_d;
  logic signed [WEIGHT_W-1:0] sel_best_q, sel_best_d;
  logic [VTX_W-1:0] sel_idx_q, sel_idx_d;

  logic done_d, status_d, hasp_d, joined_d;
  logic [VTX_W-1:0] parent_d;
  logic [WEIGHT_W-1:0] weight_d;
  logic [VTX_W-1:0] parent_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic done_q, status_q, hasp_q, joined_q;

  logic               adj_we;
  logic [ADJ_AW-1:0]  adj_waddr, adj_raddr;
  logic [ADJ_DW-1:0]  adj_wdata, adj_rdata;
  logic               vm_we;
  logic [VTX_W-1:0]   vm_waddr, vm_raddr;
  logic [VMEM_DW-1:0] vm_wdata, vm_rdata;

  logic accept;
  logic signed [WEIGHT_W-1:0] aw, vb, nb;
  logic relax, cand, take;

  pmst_adj_ram u_adj (
    .clk_i  (clk_i),
    .we_i   (adj_we),
    .waddr_i(adj_waddr),
    .wdata_i(adj_wdata),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  pmst_vtx_ram u_vtx (
    .clk_i  (clk_i),
    .we_i   (vm_we),
    .waddr_i(vm_waddr),
    .wdata_i(vm_wdata),
    .raddr_i(vm_raddr),
    .rdata_o(vm_rdata)
  );

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // scan evaluation of the entry whose read data is arriving
  assign aw    = adj_rdata[WEIGHT_W-1:0];
  assign vb    = vm_rdata[VMEM_DW-1:VTX_W];
  assign relax = adj_rdata[ADJ_DW-1] && !in_tree_q[pend_y_q] &&
                 (!reached_q[pend_y_q] || (aw > vb));
  assign nb    = relax ? aw : vb;
  assign cand  = (reached_q[pend_y_q] || relax) && !in_tree_q[pend_y_q];
  assign take  = cand && (!found_q || (nb > sel_best_q));

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    clr_report_d = clr_report_q;
    x_d          = x_q;
    in_tree_d    = in_tree_q;
    reached_d    = reached_q;
    pv_d         = pv_q;
    iss_y_d      = iss_y_q;
    iss_on_d     = iss_on_q;
    pend_d       = 1'b0;
    pend_y_d     = iss_y_q;
    found_d      = found_q;
    sel_best_d   = sel_best_q;
    sel_idx_d    = sel_idx_q;
    done_d       = 1'b0;
    status_d     = 1'b0;
    parent_d     = '0;
    hasp_d       = 1'b0;
    weight_d     = '0;
    joined_d     = 1'b0;
    adj_we       = 1'b0;
    adj_waddr    = clr_addr_q;
    adj_wdata    = '0;
    adj_raddr    = {x_q, iss_y_q};
    vm_we        = 1'b0;
    vm_waddr     = pend_y_q;
    vm_wdata     = {aw, x_q};
    vm_raddr     = iss_y_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_e'(mode_i))
            MODE_CLEAR: begin
              state_d      = S_CLEAR;
              clr_addr_d   = '0;
              clr_report_d = 1'b1;
            end
            MODE_ADD: begin
              if (from_vertex_i > top_q || to_vertex_i > top_q) begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end else begin
                adj_raddr = {from_vertex_i, to_vertex_i};
                state_d   = S_EDGE;
              end
            end
            MODE_RUN: begin
              if (start_vertex_i > top_q) begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end else begin
                vm_we     = 1'b1;
                vm_waddr  = start_vertex_i;
                vm_wdata  = '0;
                x_d       = start_vertex_i;
                in_tree_d = '0;
                reached_d = '0;
                pv_d      = '0;
                in_tree_d[start_vertex_i] = 1'b1;
                reached_d[start_vertex_i] = 1'b1;
                iss_y_d   = '0;
                iss_on_d  = 1'b1;
                found_d   = 1'b0;
                state_d   = S_SCAN;
              end
            end
            default: begin
              if (query_vertex_i > top_q) begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end else begin
                vm_raddr = query_vertex_i;
                state_d  = S_QUERY;
              end
            end
          endcase
        end
      end
      S_CLEAR: begin
        adj_we     = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          state_d      = S_IDLE;
          done_d       = clr_report_q;
          clr_report_d = 1'b0;
        end
      end
      S_EDGE: begin
        adj_waddr = {from_q, to_q};
        adj_wdata = {1'b1, w_q};
        adj_we    = !adj_rdata[ADJ_DW-1] || ($signed(w_q) > aw);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_QUERY: begin
        done_d   = 1'b1;
        hasp_d   = pv_q[qv_q];
        parent_d = pv_q[qv_q] ? vm_rdata[VTX_W-1:0] : '0;
        weight_d = reached_q[qv_q] ? vm_rdata[VMEM_DW-1:VTX_W] : '0;
        joined_d = in_tree_q[qv_q];
        state_d  = S_IDLE;
      end
      S_SCAN: begin
        if (iss_on_q) begin
          pend_d = 1'b1;
          if (iss_y_q == top_q) begin
            iss_on_d = 1'b0;
          end else begin
            iss_y_d = iss_y_q + 1'b1;
          end
        end
        if (pend_q) begin
          if (relax) begin
            vm_we               = 1'b1;
            reached_d[pend_y_q] = 1'b1;
            pv_d[pend_y_q]      = 1'b1;
          end
          if (take) begin
            found_d    = 1'b1;
            sel_best_d = nb;
            sel_idx_d  = pend_y_q;
          end
          if (pend_y_q == top_q) begin
            // end of row: join the chosen vertex or finish
            if (found_q || take) begin
              x_d = take ? pend_y_q : sel_idx_q;
              in_tree_d[take ? pend_y_q : sel_idx_q] = 1'b1;
              iss_y_d  = '0;
              iss_on_d = 1'b1;
              found_d  = 1'b0;
            end else begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      clr_report_q <= 1'b0;
      top_q        <= VTX_W'(NUM_V - 1);
      in_tree_q    <= '0;
      reached_q    <= '0;
      pv_q         <= '0;
      iss_on_q     <= 1'b0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      clr_report_q <= clr_report_d;
      if (cfg_we_i) begin
        top_q <= cfg_wdata_i;
      end
      in_tree_q    <= in_tree_d;
      reached_q    <= reached_d;
      pv_q         <= pv_d;
      iss_on_q     <= iss_on_d;
      pend_q       <= pend_d;
      found_q      <= found_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      from_q <= from_vertex_i;
      to_q   <= to_vertex_i;
      w_q    <= edge_weight_i;
      qv_q   <= query_vertex_i;
    end
    x_q        <= x_d;
    iss_y_q    <= iss_y_d;
    pend_y_q   <= pend_y_d;
    sel_best_q <= sel_best_d;
    sel_idx_q  <= sel_idx_d;
    status_q   <= status_d;
    parent_q   <= parent_d;
    hasp_q     <= hasp_d;
    weight_q   <= weight_d;
    joined_q   <= joined_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign tree_parent_o = parent_q;
  assign has_parent_o  = hasp_q;
  assign tree_weight_o = weight_q;
  assign joined_tree_o = joined_q;

endmodule

// ===== rtl/pmst_checker.sv =====
// Port-level checks for prim_max_spanning_tree_top, attached by bind.
// Depends on nothing but the top level's port names.
module pmst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        status_o,
  input logic [5:0]  tree_parent_o,
  input logic        has_parent_o,
  input logic [15:0] tree_weight_o,
  input logic        joined_tree_o
);

  // a taken transaction either answers at once or holds the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (done_o || busy_o))
    else $error("accepted transaction neither answered nor busy");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (tree_parent_o == 6'd0 && !has_parent_o &&
                              tree_weight_o == 16'd0 && !joined_tree_o))
    else $error("error result carries nonzero fields");

  a_no_parent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !has_parent_o) |-> (tree_parent_o == 6'd0))
    else $error("parent index without parent edge");

endmodule

bind prim_max_spanning_tree_top pmst_checker u_pmst_checker (.*);

// ===== bench/prim_max_spanning_tree_checker.sv =====
// Checker for the maximum spanning tree block: watches the command and result
// channels, keeps its own graph and tree state, and compares every result.
// Depends on pmst_pkg.
module prim_max_spanning_tree_checker
  import pmst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         mode_i,
  input  logic [5:0]         from_vertex_i,
  input  logic [5:0]         to_vertex_i,
  input  logic signed [15:0] edge_weight_i,
  input  logic [5:0]         start_vertex_i,
  input  logic [5:0]         query_vertex_i,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               done_i,
  input  logic               status_i,
  input  logic [5:0]         tree_parent_i,
  input  logic               has_parent_i,
  input  logic signed [15:0] tree_weight_i,
  input  logic               joined_tree_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic               status;
    logic [5:0]         tree_parent;
    logic               has_parent;
    logic signed [15:0] tree_weight;
    logic               joined_tree;
  } tree_entry_t;

  tree_entry_t expected_q[$];

  logic signed [15:0] adj_w   [NUM_V*NUM_V];
  logic               adj_vld [NUM_V*NUM_V];
  logic               in_tree [NUM_V];
  logic               reached [NUM_V];
  logic               par_vld [NUM_V];
  logic signed [15:0] best_w  [NUM_V];
  logic [5:0]         par_idx [NUM_V];
  logic [5:0]         highest_v;

  int fails;
  int checked;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();
  assign checked_o    = checked;

  function automatic void grow_tree_from(input int s, input int top);
    int x, y, e, nxt;
    bit found;
    logic signed [15:0] best;
    for (int i = 0; i < NUM_V; i++) begin
      in_tree[i] = 1'b0; reached[i] = 1'b0; par_vld[i] = 1'b0;
      best_w[i] = '0; par_idx[i] = '0;
    end
    reached[s] = 1'b1;
    x = s;
    while (1) begin
      in_tree[x] = 1'b1;
      for (y = 0; y <= top; y++) begin
        e = x * NUM_V + y;
        if (!adj_vld[e] || in_tree[y]) continue;
        if (!reached[y] || adj_w[e] > best_w[y]) begin
          best_w[y] = adj_w[e];
          par_idx[y] = x[5:0];
          par_vld[y] = 1'b1;
          reached[y] = 1'b1;
        end
      end
      found = 1'b0;
      best = '0;
      nxt = 0;
      for (y = 0; y <= top; y++) begin
        if (in_tree[y] || !reached[y]) continue;
        // lowest index wins a tie: strictly greater only
        if (!found || best_w[y] > best) begin
          found = 1'b1;
          best = best_w[y];
          nxt = y;
        end
      end
      if (!found) break;
      x = nxt;
    end
  endfunction

  function automatic tree_entry_t predict_command();
    tree_entry_t r;
    int top;
    int e;
    r = '0;
    top = highest_v;
    case (mode_e'(mode_i))
      MODE_CLEAR: for (int i = 0; i < NUM_V*NUM_V; i++) adj_vld[i] = 1'b0;
      MODE_ADD: begin
        if (from_vertex_i > top || to_vertex_i > top) begin
          r.status = 1'b1;
        end else begin
          e = from_vertex_i * NUM_V + to_vertex_i;
          if (!adj_vld[e] || edge_weight_i > adj_w[e]) adj_w[e] = edge_weight_i;
          adj_vld[e] = 1'b1;
        end
      end
      MODE_RUN: begin
        if (start_vertex_i > top) r.status = 1'b1;
        else grow_tree_from(start_vertex_i, top);
      end
      default: begin
        if (query_vertex_i > top) begin
          r.status = 1'b1;
        end else begin
          if (par_vld[query_vertex_i]) begin
            r.tree_parent = par_idx[query_vertex_i];
            r.has_parent = 1'b1;
          end
          if (reached[query_vertex_i]) r.tree_weight = best_w[query_vertex_i];
          r.joined_tree = in_tree[query_vertex_i];
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    fails = 0;
    checked = 0;
    highest_v = 6'd63;
    for (int i = 0; i < NUM_V*NUM_V; i++) begin
      adj_vld[i] = 1'b0; adj_w[i] = '0;
    end
    for (int i = 0; i < NUM_V; i++) begin
      in_tree[i] = 1'b0; reached[i] = 1'b0; par_vld[i] = 1'b0;
      best_w[i] = '0; par_idx[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    tree_entry_t exp_r;
    if (rst_ni) begin
      // result first: it can never belong to a command taken at this edge
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no command outstanding");
          fails++;
        end else begin
          exp_r = expected_q.pop_front();
          checked++;
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_i);
            fails++;
          end
          if (tree_parent_i !== exp_r.tree_parent) begin
            $error("tree_parent: expected %0d, got %0d", exp_r.tree_parent, tree_parent_i);
            fails++;
          end
          if (has_parent_i !== exp_r.has_parent) begin
            $error("has_parent: expected %0d, got %0d", exp_r.has_parent, has_parent_i);
            fails++;
          end
          if (tree_weight_i !== exp_r.tree_weight) begin
            $error("tree_weight: expected %0d, got %0d", exp_r.tree_weight, tree_weight_i);
            fails++;
          end
          if (joined_tree_i !== exp_r.joined_tree) begin
            $error("joined_tree: expected %0d, got %0d", exp_r.joined_tree, joined_tree_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) expected_q.push_back(predict_command());
      if (cfg_we_i) highest_v = cfg_wdata_i;
    end
  end

endmodule

// ===== bench/prim_max_spanning_tree_top_tb.sv =====
// Testbench top for the maximum spanning tree block: clock, reset, command
// stimulus and verdict. Depends on pmst_pkg, prim_max_spanning_tree_checker and the top.
module prim_max_spanning_tree_top_tb;
  import pmst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         mode_i = MODE_CLEAR;
  logic [5:0]         from_vertex_i = '0;
  logic [5:0]         to_vertex_i = '0;
  logic signed [15:0] edge_weight_i = '0;
  logic [5:0]         start_vertex_i = '0;
  logic [5:0]         query_vertex_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [5:0]         cfg_wdata_i = '0;
  logic               done_o;
  logic               status_o;
  logic [5:0]         tree_parent_o;
  logic               has_parent_o;
  logic signed [15:0] tree_weight_o;
  logic               joined_tree_o;

  int fail_count, pending, checked;
  int cycles = 0;
  int sent = 0;
  int runs = 0;
  int cfg_writes = 0;
  logic [5:0] hv = 6'd63;

  always #5 clk_i = ~clk_i;

  prim_max_spanning_tree_top u_dut (.*);

  prim_max_spanning_tree_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .from_vertex_i,
    .to_vertex_i, .edge_weight_i, .start_vertex_i, .query_vertex_i,
    .cfg_we_i, .cfg_wdata_i, .done_i(done_o), .status_i(status_o),
    .tree_parent_i(tree_parent_o), .has_parent_i(has_parent_o),
    .tree_weight_i(tree_weight_o), .joined_tree_i(joined_tree_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // start stays high between back-to-back transactions; lowered once otherwise
  task automatic send(input mode_e m, input int f, input int t, input int w,
                      input int s, input int q);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0 || busy_o) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      while (busy_o) @(negedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= m;
    from_vertex_i <= f[5:0];
    to_vertex_i <= t[5:0];
    edge_weight_i <= w[15:0];
    start_vertex_i <= s[5:0];
    query_vertex_i <= q[5:0];
    @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    if (m == MODE_RUN) runs++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic set_highest(input int v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[5:0];
    hv = v[5:0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_vertex();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, hv);
  endfunction

  int phase_hv[8] = '{2, 7, 0, 15, 3, 63, 4, 1};

  initial begin
    int ph;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    set_highest(5);
    send(MODE_ADD, 0, 1, 32767, 0, 0);
    send(MODE_ADD, 0, 1, -32768, 0, 0);   // duplicate, smaller weight dropped
    send(MODE_ADD, 1, 2, -32768, 0, 0);
    send(MODE_ADD, 2, 1, 100, 0, 0);
    send(MODE_ADD, 1, 3, 256, 0, 0);
    send(MODE_ADD, 1, 4, 256, 0, 0);      // tie with vertex 3
    send(MODE_ADD, 3, 4, -1, 0, 0);
    send(MODE_ADD, 3, 3, 5, 0, 0);        // self loop
    send(MODE_ADD, 0, 6, 7, 0, 0);        // bad edge ends
    send(MODE_ADD, 6, 0, 7, 0, 0);
    send(MODE_ADD, 63, 63, 7, 0, 0);
    send(MODE_RUN, 0, 0, 0, 0, 0);
    for (int v = 0; v <= 6; v++) send(MODE_QUERY, 0, 0, 0, 0, v);
    send(MODE_RUN, 0, 0, 0, 63, 0);       // bad start
    send(MODE_CLEAR, 0, 0, 0, 0, 0);
    send(MODE_QUERY, 0, 0, 0, 0, 2);      // tree survives a clear
    send(MODE_RUN, 0, 0, 0, 1, 0);        // lone start vertex
    send(MODE_QUERY, 0, 0, 0, 0, 1);
    send(MODE_QUERY, 0, 0, 0, 0, 2);

    // random part: add/run/query groups per graph size, with occasional clears and out-of-range vertices
    ph = 0;
    while (sent < 130) begin
      set_highest(phase_hv[ph % 8]);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0) send(MODE_CLEAR, 0, 0, 0, 0, 0);
        repeat ($urandom_range(2, (hv > 8) ? 14 : 6))
          send(MODE_ADD, pick_vertex(), pick_vertex(), $urandom_range(0, 65535), 0, 0);
        send(MODE_RUN, 0, 0, 0, pick_vertex(), 0);
        repeat ($urandom_range(2, 5)) send(MODE_QUERY, 0, 0, 0, 0, pick_vertex());
        if ($urandom_range(0, 3) == 0) drain();
      end
      ph++;
    end
    set_highest(63);

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d commands (%0d tree runs), %0d results checked, %0d config writes.",
             sent, runs, checked, cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== prim_max_spanning_tree_top.f =====
rtl/pmst_pkg.sv
rtl/pmst_adj_ram.sv
rtl/pmst_vtx_ram.sv
rtl/prim_max_spanning_tree_top.sv
rtl/pmst_checker.sv
bench/prim_max_spanning_tree_checker.sv
bench/prim_max_spanning_tree_top_tb.sv
